[rtl/core/assert_macros.svh]
// Assertion macros used by the parser top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while the active-low reset is asserted.
`define ACFP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ACFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/acfp_pkg.sv]
// Shared types, constants and helpers of the ASCII CAN frame parser.
package acfp_pkg;

  // Line buffer capacity in characters (27..256).
  localparam int LineCapacity = 32;
  localparam logic [7:0] CountMax = 8'(LineCapacity - 1);

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChStd   = 8'h74;  // 't'
  localparam logic [7:0] ChExt   = 8'h54;  // 'T'
  localparam logic [7:0] MinLine = 8'd5;
  localparam logic [3:0] MaxDlc  = 4'd8;
  localparam logic [7:0] IdLenStd = 8'd3;
  localparam logic [7:0] IdLenExt = 8'd8;

  typedef enum logic [1:0] {
    KindNone  = 2'd0,
    KindStd   = 2'd1,
    KindExt   = 2'd2,
    KindOther = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StShort   = 3'd1,
    StBadType = 3'd2,
    StBadId   = 3'd3,
    StBadDlc  = 3'd4,
    StDlcOver = 3'd5,
    StLength  = 3'd6,
    StBadData = 3'd7
  } status_e;

  // Input byte held in the input register.
  typedef struct packed {
    logic       vld;
    logic [7:0] chr;
  } stage_t;

  // One parsed line result.
  typedef struct packed {
    status_e     status;
    logic        extended;
    logic [31:0] ident;
    logic [3:0]  length_code;
    logic [63:0] payload;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

  // Strict hex digit decode: 0-9, A-F, a-f only.
  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.nib = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.nib = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      h.nib = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

[rtl/core/acfp_ifs.sv]
// Valid/ready channel interfaces for received bytes and parse results.
interface acfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface acfp_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        extended;
  logic [31:0] ident;
  logic [3:0]  length_code;
  logic [63:0] payload;

  modport source (output valid, output status, output extended, output ident,
                  output length_code, output payload, input ready);
  modport sink (input valid, input status, input extended, input ident,
                input length_code, input payload, output ready);
endinterface

[rtl/core/acfp_in_stage.sv]
// Input register: captures one received byte per request.
module acfp_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  acfp_rx_if.sink             rx_i,
  input  logic                adv_i,
  output acfp_pkg::stage_t    stg_o
);

  logic       vld_q, vld_d;
  logic [7:0] chr_q;
  logic       take;

  // Refill whenever empty or the held byte moves on this cycle.
  assign rx_i.ready = !vld_q || adv_i;
  assign take       = rx_i.valid && rx_i.ready;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (adv_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      chr_q <= rx_i.rx_byte;
    end
  end

  assign stg_o.vld = vld_q;
  assign stg_o.chr = chr_q;

endmodule

[rtl/core/acfp_line_state.sv]
// Line accumulators and end-of-line status evaluation.
module acfp_line_state (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  acfp_pkg::stage_t stg_i,
  input  logic             adv_i,
  output acfp_pkg::res_t   res_o
);

  logic [7:0]      count_q, count_d;
  acfp_pkg::kind_e kind_q, kind_d;
  logic [31:0]     id_q, id_d;
  logic [3:0]      dlc_q, dlc_d;
  logic [63:0]     pay_q, pay_d;
  logic            err_id_q, err_id_d;
  logic            err_dlc_q, err_dlc_d;
  logic            err_dat_q, err_dat_d;

  acfp_pkg::hex_t  hx;
  logic [7:0]      id_len;
  logic [7:0]      dq;
  logic [3:0]      nib_idx;
  logic [7:0]      exp_len;
  logic            is_cr;
  logic            framed;

  assign hx      = acfp_pkg::hex_decode(stg_i.chr);
  assign is_cr   = (stg_i.chr == acfp_pkg::ChCr);
  assign framed  = (kind_q == acfp_pkg::KindStd) || (kind_q == acfp_pkg::KindExt);
  assign id_len  = (kind_q == acfp_pkg::KindExt) ? acfp_pkg::IdLenExt : acfp_pkg::IdLenStd;
  // Payload digit position and its nibble slot (high nibble of each byte first).
  assign dq      = count_q - id_len - 8'd2;
  assign nib_idx = {dq[3:1], ~dq[0]};
  assign exp_len = id_len + 8'd2 + {3'd0, dlc_q, 1'b0};

  // Per-byte accumulator update
  always_comb begin
    count_d   = count_q;
    kind_d    = kind_q;
    id_d      = id_q;
    dlc_d     = dlc_q;
    pay_d     = pay_q;
    err_id_d  = err_id_q;
    err_dlc_d = err_dlc_q;
    err_dat_d = err_dat_q;
    if (adv_i) begin
      if (is_cr || (count_q >= acfp_pkg::CountMax)) begin
        // End of line, or overflow: restart the line.
        count_d   = 8'd0;
        kind_d    = acfp_pkg::KindNone;
        id_d      = 32'd0;
        dlc_d     = 4'd0;
        pay_d     = 64'd0;
        err_id_d  = 1'b0;
        err_dlc_d = 1'b0;
        err_dat_d = 1'b0;
      end else begin
        count_d = count_q + 8'd1;
        if (count_q == 8'd0) begin
          if (stg_i.chr == acfp_pkg::ChStd) begin
            kind_d = acfp_pkg::KindStd;
          end else if (stg_i.chr == acfp_pkg::ChExt) begin
            kind_d = acfp_pkg::KindExt;
          end else begin
            kind_d = acfp_pkg::KindOther;
          end
        end else if (framed) begin
          if (count_q <= id_len) begin
            if (hx.ok) id_d = {id_q[27:0], hx.nib};
            else       err_id_d = 1'b1;
          end else if (count_q == id_len + 8'd1) begin
            if (hx.ok) dlc_d = hx.nib;
            else       err_dlc_d = 1'b1;
          end else if (!hx.ok) begin
            err_dat_d = 1'b1;
          end else if (dq[7:4] == 4'd0) begin
            for (int i = 0; i < 16; i++) begin
              if (nib_idx == 4'(i)) pay_d[4*i +: 4] = pay_q[4*i +: 4] | hx.nib;
            end
          end
        end
      end
    end
  end

  // Status of the line held so far, first failing check wins
  always_comb begin
    res_o = '0;
    if (count_q < acfp_pkg::MinLine) begin
      res_o.status = acfp_pkg::StShort;
    end else if (!framed) begin
      res_o.status = acfp_pkg::StBadType;
    end else if (err_id_q || (count_q <= id_len)) begin
      res_o.status = acfp_pkg::StBadId;
    end else if (err_dlc_q || (count_q < id_len + 8'd2)) begin
      res_o.status = acfp_pkg::StBadDlc;
    end else if (dlc_q > acfp_pkg::MaxDlc) begin
      res_o.status = acfp_pkg::StDlcOver;
    end else if (count_q != exp_len) begin
      res_o.status = acfp_pkg::StLength;
    end else if (err_dat_q) begin
      res_o.status = acfp_pkg::StBadData;
    end else begin
      res_o.status      = acfp_pkg::StOk;
      res_o.extended    = (kind_q == acfp_pkg::KindExt);
      res_o.ident       = id_q;
      res_o.length_code = dlc_q;
      res_o.payload     = pay_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= 8'd0;
      kind_q    <= acfp_pkg::KindNone;
      id_q      <= 32'd0;
      dlc_q     <= 4'd0;
      pay_q     <= 64'd0;
      err_id_q  <= 1'b0;
      err_dlc_q <= 1'b0;
      err_dat_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      kind_q    <= kind_d;
      id_q      <= id_d;
      dlc_q     <= dlc_d;
      pay_q     <= pay_d;
      err_id_q  <= err_id_d;
      err_dlc_q <= err_dlc_d;
      err_dat_q <= err_dat_d;
    end
  end

endmodule

[rtl/core/acfp_res_reg.sv]
// Result register driving the result channel.
module acfp_res_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  acfp_pkg::res_t res_i,
  output logic           space_o,
  acfp_res_if.source     res_o
);

  logic           vld_q, vld_d;
  acfp_pkg::res_t res_q;

  // Free when empty or the held result is taken this cycle.
  assign space_o = !vld_q || res_o.ready;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (res_o.ready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid       = vld_q;
  assign res_o.status      = res_q.status;
  assign res_o.extended    = res_q.extended;
  assign res_o.ident       = res_q.ident;
  assign res_o.length_code = res_q.length_code;
  assign res_o.payload     = res_q.payload;

endmodule

[rtl/core/ascii_can_frame_parser_unit.sv]
// Top level of the ASCII CAN frame parser.
//
// rx_i takes one received character per request (valid/ready). Lines are
// 't' + 3 hex id digits or 'T' + 8, one hex DLC digit, DLC hex byte pairs,
// ended by carriage return. Each carriage return produces one request on
// res_o with a status code; id, extended flag, DLC and payload are zero
// unless the status is ok. Other characters produce no result.
// A byte waits in the input register and is folded into the line accumulators
// as it leaves; a carriage return's result is then loaded into the result
// register that drives res_o.
// Throughput: one character per cycle unless a carriage return waits for a
// full result register; the accumulator update sits between the two registers.
// When res_o stalls, ordinary characters keep flowing; a carriage return
// waits in the input register until the result register is free, and rx_i
// backs up behind it.
// Reset (rst_ni, asynchronous) empties both registers and clears the line.
`include "assert_macros.svh"

module ascii_can_frame_parser_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  acfp_rx_if.sink      rx_i,
  acfp_res_if.source   res_o
);

  acfp_pkg::stage_t stg;
  acfp_pkg::res_t   line_res;
  logic             adv;
  logic             res_space;
  logic             res_load;
  logic             stg_cr;

  assign stg_cr   = (stg.chr == acfp_pkg::ChCr);
  // A held byte advances unless it is a carriage return facing a full result register.
  assign adv      = stg.vld && (!stg_cr || res_space);
  assign res_load = adv && stg_cr;

  acfp_in_stage u_in (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_i),
    .adv_i  (adv),
    .stg_o  (stg)
  );

  acfp_line_state u_line (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stg_i  (stg),
    .adv_i  (adv),
    .res_o  (line_res)
  );

  acfp_res_reg u_res (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_load),
    .res_i   (line_res),
    .space_o (res_space),
    .res_o   (res_o)
  );

  // Checks
  `ACFP_ASSERT(a_err_fields_zero, clk_i, rst_ni,
    (res_o.valid && res_o.status != acfp_pkg::StOk) |->
      (res_o.ident == 32'd0 && res_o.payload == 64'd0 &&
       res_o.length_code == 4'd0 && !res_o.extended),
    "failed line carries nonzero fields")
  `ACFP_ASSERT(a_ok_dlc_range, clk_i, rst_ni,
    (res_o.valid && res_o.status == acfp_pkg::StOk) |->
      (res_o.length_code <= acfp_pkg::MaxDlc),
    "ok result with DLC above 8")
  `ACFP_ASSERT(a_cr_held, clk_i, rst_ni,
    (stg.vld && !adv) |=> (stg.vld && $stable(stg.chr)), "stalled carriage return lost")
  `ACFP_ASSERT(a_load_shows, clk_i, rst_ni, res_load |=> res_o.valid,
    "loaded result not presented")

endmodule
